@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BHD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("button detector assertion failed");

// Check a property on every clock edge, reset included.
`define BHD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("button detector assertion failed");

`endif

@@ rtl/bhd_pkg.sv @@
// Shared types and constants of the button hold and double-tap detector.
`default_nettype none

package bhd_pkg;

    // Detector phases; codes not listed behave as idle
    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_TIMING       = 3'd1,
        PH_WAIT_RELEASE = 3'd2,
        PH_WINDOW       = 3'd3,
        PH_SECOND       = 3'd4
    } t_phase;

    // Register indexes, taken from address bit 2
    localparam logic REG_HOLD   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [15:0] HOLD_RESET   = 16'd250;
    localparam logic [15:0] WINDOW_RESET = 16'd25;

    // Register contents handed to the state machine
    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [15:0] window_ticks;
    } t_cfg;

    // One result word; press_indicator in the lowest bit
    typedef struct packed {
        logic double_ignored_pulse;
        logic channel_cycle_pulse;
        logic factory_reset_pulse;
        logic press_indicator;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/button_hold_and_double_tap_detector_top.sv @@
// Top level of the button hold and double-tap detector.
// Usage:
//   Slave stream: one word per 20 ms poll tick; s_axis_tdata bit 0 is the pin
//   level (0 pressed), bit 1 the AP-mode flag.
//   Master stream: exactly one result word per input word; m_axis_tdata bit 0
//   press indicator, bit 1 factory reset, bit 2 channel cycle, bit 3 ignored
//   double press.
//   APB-style port: hold_ticks at address 0, window_ticks at address 4; write
//   only while no words are in flight. pready is always high.
// Path: an accepted word goes through the input register, then through the
// state machine into the result register.
// Throughput: one word per cycle unless m_axis_tready is held low.
// Reset: phase idle, tick count zero, registers at 250 and 25, both stream
// stages empty.
// Stall: when m_axis_tready is low the result register holds its word, the
// input register keeps one more word, and s_axis_tready drops once both are
// full.
`default_nettype none

module button_hold_and_double_tap_detector_top
    import bhd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB-style configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [0] pin_level, [1] ap_mode
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata   // [0] press_indicator,
                                            // [1] factory_reset_pulse,
                                            // [2] channel_cycle_pulse,
                                            // [3] double_ignored_pulse
);

    t_cfg    cfg;
    t_result result;
    logic    r_in_valid;
    logic    r_pin_level;
    logic    r_ap_mode;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    logic    step;

    bhd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Result register frees up when empty or taken this cycle
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step          = r_in_valid && advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pin_level <= s_axis_tdata[0];
            r_ap_mode   <= s_axis_tdata[1];
        end
    end

    bhd_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pin_level (r_pin_level),
        .i_ap_mode   (r_ap_mode),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

endmodule

`default_nettype wire

@@ rtl/bhd_cfg.sv @@
// Configuration registers behind the APB-style port.
`default_nettype none

module bhd_cfg
    import bhd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_hold;
    logic [15:0] r_window;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= HOLD_RESET;
            r_window <= WINDOW_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_WINDOW) begin
                r_window <= pwdata[15:0];
            end else begin
                r_hold <= pwdata[15:0];
            end
        end
    end

    // Read back, zero extended
    always_comb begin
        if (paddr[2] == REG_WINDOW) begin
            prdata = {16'd0, r_window};
        end else begin
            prdata = {16'd0, r_hold};
        end
    end

    assign o_cfg.hold_ticks   = r_hold;
    assign o_cfg.window_ticks = r_window;

endmodule

`default_nettype wire

@@ rtl/bhd_fsm.sv @@
// Press timing state machine: phase, tick counter and result decode.
`default_nettype none

module bhd_fsm
    import bhd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_pin_level,
    input  wire logic i_ap_mode,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] count_inc;
    logic        pressed;

    assign pressed   = !i_pin_level;
    // Saturating tick count
    assign count_inc = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;

    // Advance state once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Next state and result for the current word
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        o_result = '0;
        case (r_phase)
            PH_TIMING: begin
                if (pressed) begin
                    n_count                  = count_inc;
                    o_result.press_indicator = 1'b1;
                    if (count_inc >= i_cfg.hold_ticks) begin
                        o_result.factory_reset_pulse = 1'b1;
                        n_phase                      = PH_WAIT_RELEASE;
                    end
                end else begin
                    n_phase = PH_WINDOW;
                    n_count = 16'd0;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WINDOW: begin
                n_count = count_inc;
                if (count_inc >= i_cfg.window_ticks) begin
                    n_phase = PH_IDLE;
                end else if (pressed) begin
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (!pressed) begin
                    o_result.channel_cycle_pulse  = i_ap_mode;
                    o_result.double_ignored_pulse = !i_ap_mode;
                    n_phase                       = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (pressed) begin
                    n_count                  = 16'd0;
                    o_result.press_indicator = 1'b1;
                    // A zero hold fires on the press tick itself
                    if (i_cfg.hold_ticks == 16'd0) begin
                        o_result.factory_reset_pulse = 1'b1;
                        n_phase                      = PH_WAIT_RELEASE;
                    end else begin
                        n_phase = PH_TIMING;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/bhd_checker.sv @@
// Port-level checker for the button detector, bound to the top level.
`include "assert_macros.svh"
`default_nettype none

module bhd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       pready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // At most one event pulse per word
    `BHD_ASSERT(a_one_pulse, i_clk, i_rst_n, m_axis_tvalid |-> $onehot0(m_axis_tdata[3:1]))

    // Factory reset only fires during a first press, with the press indicator set
    `BHD_ASSERT(a_reset_in_press, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])

    // A double press completes outside any first press
    `BHD_ASSERT(a_double_no_ind, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tdata[2] || m_axis_tdata[3])) |-> !m_axis_tdata[0])

    // Stalled result word holds
    `BHD_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

    // Configuration port never waits
    `BHD_ASSERT_ALWAYS(a_pready, i_clk, pready)

endmodule

bind button_hold_and_double_tap_detector_top bhd_checker u_bhd_checker (.*);

`default_nettype wire
